// ----- hw/rtl/rlecd_pkg.sv -----
// ----------------------------------------------------------------------------
// rlecd_pkg
// Shared types and constants of the container decompressor.
// ----------------------------------------------------------------------------
package rlecd_pkg;

  // format modes
  localparam logic [3:0] MD_IDLE  = 4'd0;
  localparam logic [3:0] MD_LIT   = 4'd1;
  localparam logic [3:0] MD_PHDR  = 4'd2;
  localparam logic [3:0] MD_PPAT  = 4'd3;
  localparam logic [3:0] MD_POUT  = 4'd4;
  localparam logic [3:0] MD_BHDR  = 4'd5;
  localparam logic [3:0] MD_BCTRL = 4'd6;
  localparam logic [3:0] MD_BRUNV = 4'd7;
  localparam logic [3:0] MD_BLIT  = 4'd8;
  localparam logic [3:0] MD_DONE  = 4'd9;

  // status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_FMT  = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_CRC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // config register indexes
  localparam logic [1:0] CFG_TAG_LIT = 2'd0;
  localparam logic [1:0] CFG_TAG_PER = 2'd1;
  localparam logic [1:0] CFG_TAG_BLK = 2'd2;
  localparam logic [1:0] CFG_CAP     = 2'd3;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  // one request
  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
    logic       in_last;
  } req_t;

  // one result
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] decoded_length;
  } res_t;

  // byte-wise reflected CRC-32 update
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/rle_container_decompressor_core.sv -----
// ----------------------------------------------------------------------------
// rle_container_decompressor_core
// Push/pull container decoder (literal, periodic, run/literal blocks) + CRC.
// ----------------------------------------------------------------------------
// A result goes from request accept through the result register, then the
// output stage, to the port.
// Throughput: one request per cycle, set by the decode/CRC step; input
// stalls while the skid register is full or a result waits on a held output.
// Reset: rst_n synchronous, active low; clears control state and config regs.
// The pattern memory has no reset; entries are written before they are read.
module rle_container_decompressor_core #(
  parameter int PATTERN_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] req_type
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [10:8] status,
                                  // [26:11] decoded_length, [31:27] zero
  output logic [1:0]  out_tuser,  // [0] out_valid, [1] done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  tag_lit_r, tag_per_r, tag_blk_r;
  logic [15:0] cap_r;
  rlecd_pkg::req_t req;
  rlecd_pkg::res_t res, res_o;
  logic res_v, skid_ready, acc;

  assign cfg_ready = 1'b1;
  // hold off while a result waits and the output stage cannot take it
  assign in_tready = skid_ready && !(res_v && out_tvalid && !out_tready);
  assign acc = in_tvalid && in_tready;
  assign req.req_type = in_tuser;
  assign req.in_byte  = in_tdata;
  assign req.in_last  = in_tlast;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_lit_r <= 8'd0; tag_per_r <= 8'd1; tag_blk_r <= 8'd2; cap_r <= 16'hffff;
    end else if (cfg_valid) begin
      case (cfg_index)
        rlecd_pkg::CFG_TAG_LIT: tag_lit_r <= cfg_data[7:0];
        rlecd_pkg::CFG_TAG_PER: tag_per_r <= cfg_data[7:0];
        rlecd_pkg::CFG_TAG_BLK: tag_blk_r <= cfg_data[7:0];
        default:                cap_r     <= cfg_data;
      endcase
    end
  end

  rlecd_engine #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_eng (
    .clk, .rst_n, .req_valid(acc), .req,
    .tag_lit(tag_lit_r), .tag_per(tag_per_r), .tag_blk(tag_blk_r), .cap(cap_r),
    .res_valid(res_v), .res
  );

  rlecd_out_reg u_out (
    .clk, .rst_n, .s_valid(res_v), .s_ready(skid_ready), .s_data(res),
    .m_valid(out_tvalid), .m_ready(out_tready), .m_data(res_o)
  );

  assign out_tdata = {5'd0, res_o.decoded_length, res_o.status, res_o.out_byte};
  assign out_tuser = {res_o.done_res, res_o.out_valid};

endmodule

// ----- hw/rtl/rlecd_out_reg.sv -----
// ----------------------------------------------------------------------------
// rlecd_out_reg
// Two-entry skid buffer on the result side.
// ----------------------------------------------------------------------------
module rlecd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  rlecd_pkg::res_t  s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output rlecd_pkg::res_t  m_data
);

  rlecd_pkg::res_t main_r, skid_r;
  logic main_v_r, skid_v_r;

  assign s_ready = !skid_v_r;
  assign m_valid = main_v_r;
  assign m_data  = main_r;

  // main register feeds the port, skid catches one result during a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r || m_ready) begin
        if (skid_v_r) begin
          main_r   <= skid_r;
          main_v_r <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          main_r   <= s_data;
          main_v_r <= s_valid;
        end
      end else if (s_valid && s_ready) begin
        skid_r   <= s_data;
        skid_v_r <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rlecd_engine.sv -----
// ----------------------------------------------------------------------------
// rlecd_engine
// Decoder state, pattern memory and CRC; one request handled per cycle.
// ----------------------------------------------------------------------------
module rlecd_engine #(
  parameter int PATTERN_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  rlecd_pkg::req_t  req,
  input  logic [7:0]       tag_lit,
  input  logic [7:0]       tag_per,
  input  logic [7:0]       tag_blk,
  input  logic [15:0]      cap,
  output logic             res_valid,
  output rlecd_pkg::res_t  res
);

  localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

  logic [3:0]  mode_r, mode_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [2:0]  verdict_r, verdict_nxt;
  logic [15:0] exp_len_r, exp_len_nxt;
  logic [31:0] exp_crc_r, exp_crc_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [23:0] cnt_r, cnt_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        is_run_r, is_run_nxt;
  logic [7:0]  run_val_r, run_val_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic [7:0]  period_r, period_nxt;
  logic [15:0] reps_r, reps_nxt;
  logic [8:0]  pidx_r, pidx_nxt;
  logic        ended_r, ended_nxt;

  logic [7:0]  mem [PATTERN_DEPTH];
  logic        wr_en;
  logic [AW-1:0] wr_addr;

  // pattern output is read ahead: pat_q_r holds the entry at pidx_r
  logic [7:0]  pat_q_r;
  logic [8:0]  rd_idx;

  rlecd_pkg::res_t r;
  logic [7:0]  gb;
  logic        give;
  logic [2:0]  fin_st;
  logic        fin;
  logic [31:0] prod;
  logic [7:0]  cnt_c;
  logic [15:0] repn;
  logic [24:0] cnt1;

  always_comb begin
    mode_nxt = mode_r; hidx_nxt = hidx_r; verdict_nxt = verdict_r;
    exp_len_nxt = exp_len_r; exp_crc_nxt = exp_crc_r; crc_nxt = crc_r;
    cnt_nxt = cnt_r; pend_nxt = pend_r; is_run_nxt = is_run_r;
    run_val_nxt = run_val_r; held_nxt = held_r; held_v_nxt = held_v_r;
    period_nxt = period_r; reps_nxt = reps_r; pidx_nxt = pidx_r;
    ended_nxt = ended_r;
    wr_en = 1'b0; wr_addr = pidx_r[AW-1:0];
    gb = 8'd0; give = 1'b0; fin = 1'b0; fin_st = rlecd_pkg::ST_OK;
    r = '0; r.status = rlecd_pkg::ST_OK;
    prod = 32'd0; cnt_c = 8'd0; repn = 16'd0;
    cnt1 = {1'b0, cnt_r} + 25'd1;
    if (mode_r == rlecd_pkg::MD_DONE) begin
      r.done_res = 1'b1; r.status = verdict_r;
    end else if (!req.req_type) begin
      // push
      if (ended_r) begin
        fin = 1'b1; fin_st = rlecd_pkg::ST_FMT;
      end else begin
        case (mode_r)
          rlecd_pkg::MD_IDLE: begin
            if (req.in_byte == tag_lit) begin
              mode_nxt = rlecd_pkg::MD_LIT;
              if (req.in_last) begin fin = 1'b1; fin_st = rlecd_pkg::ST_LEN; end
            end else if (req.in_byte == tag_per) begin
              mode_nxt = rlecd_pkg::MD_PHDR; hidx_nxt = 3'd0;
              if (req.in_last) begin fin = 1'b1; fin_st = rlecd_pkg::ST_FMT; end
            end else if (req.in_byte == tag_blk) begin
              mode_nxt = rlecd_pkg::MD_BHDR; hidx_nxt = 3'd0;
              if (req.in_last) begin fin = 1'b1; fin_st = rlecd_pkg::ST_FMT; end
            end else begin
              fin = 1'b1; fin_st = rlecd_pkg::ST_FMT;
            end
          end
          rlecd_pkg::MD_LIT: begin
            if (held_v_r) r.status = rlecd_pkg::ST_WAIT;
            else if (cnt1 > {9'd0, cap}) begin fin = 1'b1; fin_st = rlecd_pkg::ST_LEN; end
            else begin
              held_nxt = req.in_byte; held_v_nxt = 1'b1;
              if (req.in_last) ended_nxt = 1'b1;
            end
          end
          rlecd_pkg::MD_PHDR: begin
            if (req.in_last) begin fin = 1'b1; fin_st = rlecd_pkg::ST_FMT; end
            else if (hidx_r == 3'd0) begin
              period_nxt = req.in_byte; hidx_nxt = 3'd1;
            end else if (hidx_r == 3'd1) begin
              reps_nxt = {8'd0, req.in_byte}; hidx_nxt = 3'd2;
            end else begin
              repn = {req.in_byte, reps_r[7:0]};
              reps_nxt = repn;
              prod = {16'd0, 8'd0, period_r} * {16'd0, repn};
              hidx_nxt = 3'd3;
              if (period_r == 8'd0 || repn == 16'd0) begin
                fin = 1'b1; fin_st = rlecd_pkg::ST_FMT;
              end else if (prod > {16'd0, cap}
                           || {1'b0, period_r} > 9'(PATTERN_DEPTH)) begin
                fin = 1'b1; fin_st = rlecd_pkg::ST_LEN;
              end else begin
                mode_nxt = rlecd_pkg::MD_PPAT; pidx_nxt = 9'd0;
              end
            end
          end
          rlecd_pkg::MD_PPAT: begin
            wr_en = (pidx_r < 9'(PATTERN_DEPTH));
            pidx_nxt = pidx_r + 9'd1;
            if (pidx_nxt >= {1'b0, period_r}) begin
              if (!req.in_last) begin fin = 1'b1; fin_st = rlecd_pkg::ST_FMT; end
              else begin
                ended_nxt = 1'b1; mode_nxt = rlecd_pkg::MD_POUT; pidx_nxt = 9'd0;
              end
            end else if (req.in_last) begin
              fin = 1'b1; fin_st = rlecd_pkg::ST_FMT;
            end
          end
          rlecd_pkg::MD_BHDR: begin
            if (req.in_last && hidx_r < 3'd6) begin
              fin = 1'b1; fin_st = rlecd_pkg::ST_FMT;
            end else if (hidx_r == 3'd0 && req.in_byte != 8'd1) begin
              fin = 1'b1; fin_st = rlecd_pkg::ST_FMT;
            end else begin
              case (hidx_r)
                3'd0: ;
                3'd1: exp_len_nxt = {8'd0, req.in_byte};
                3'd2: exp_len_nxt = {req.in_byte, exp_len_r[7:0]};
                3'd3: exp_crc_nxt = exp_crc_r | {24'd0, req.in_byte};
                3'd4: exp_crc_nxt = exp_crc_r | {16'd0, req.in_byte, 8'd0};
                3'd5: exp_crc_nxt = exp_crc_r | {8'd0, req.in_byte, 16'd0};
                default: exp_crc_nxt = exp_crc_r | {req.in_byte, 24'd0};
              endcase
              if (hidx_r >= 3'd6) begin
                if (exp_len_nxt == 16'd0 || exp_len_nxt > cap || req.in_last) begin
                  fin = 1'b1; fin_st = rlecd_pkg::ST_LEN;
                end else mode_nxt = rlecd_pkg::MD_BCTRL;
              end
              hidx_nxt = hidx_r + 3'd1;
            end
          end
          rlecd_pkg::MD_BCTRL: begin
            cnt_c = {1'b0, req.in_byte[6:0]} + 8'd1;
            if (held_v_r || pend_r != 8'd0) r.status = rlecd_pkg::ST_WAIT;
            else if (req.in_last) begin fin = 1'b1; fin_st = rlecd_pkg::ST_FMT; end
            else if ({8'd0, cnt_c} > ({8'd0, exp_len_r} - {8'd0, cnt_r[15:0]})
                     || cnt_r[23:16] != 8'd0) begin
              // unsigned wrap of expected minus produced never lets a block fail
              // unless it really exceeds; produced never passes expected here
              fin = 1'b1; fin_st = rlecd_pkg::ST_LEN;
            end else begin
              pend_nxt = cnt_c; is_run_nxt = req.in_byte[7];
              mode_nxt = req.in_byte[7] ? rlecd_pkg::MD_BRUNV : rlecd_pkg::MD_BLIT;
            end
          end
          rlecd_pkg::MD_BRUNV: begin
            run_val_nxt = req.in_byte; mode_nxt = rlecd_pkg::MD_BCTRL;
            if (req.in_last) ended_nxt = 1'b1;
          end
          rlecd_pkg::MD_BLIT: begin
            if (held_v_r) r.status = rlecd_pkg::ST_WAIT;
            else if (req.in_last && pend_r != 8'd1) begin
              fin = 1'b1; fin_st = rlecd_pkg::ST_FMT;
            end else begin
              held_nxt = req.in_byte; held_v_nxt = 1'b1;
              pend_nxt = pend_r - 8'd1;
              if (pend_nxt == 8'd0) begin
                mode_nxt = rlecd_pkg::MD_BCTRL;
                if (req.in_last) ended_nxt = 1'b1;
              end
            end
          end
          default: begin fin = 1'b1; fin_st = rlecd_pkg::ST_FMT; end
        endcase
      end
    end else begin
      // pull
      r.status = rlecd_pkg::ST_WAIT;
      case (mode_r)
        rlecd_pkg::MD_LIT: begin
          if (held_v_r) begin held_v_nxt = 1'b0; give = 1'b1; gb = held_r; end
          else if (ended_r) begin fin = 1'b1; fin_st = rlecd_pkg::ST_FIN; end
        end
        rlecd_pkg::MD_POUT: begin
          if (reps_r == 16'd0) begin fin = 1'b1; fin_st = rlecd_pkg::ST_FIN; end
          else begin
            give = 1'b1; gb = pat_q_r;
            pidx_nxt = pidx_r + 9'd1;
            if (pidx_nxt >= {1'b0, period_r}) begin
              pidx_nxt = 9'd0; reps_nxt = reps_r - 16'd1;
            end
          end
        end
        rlecd_pkg::MD_BCTRL, rlecd_pkg::MD_BRUNV, rlecd_pkg::MD_BLIT: begin
          if (held_v_r) begin held_v_nxt = 1'b0; give = 1'b1; gb = held_r; end
          else if (is_run_r && pend_r != 8'd0 && mode_r != rlecd_pkg::MD_BRUNV) begin
            pend_nxt = pend_r - 8'd1; give = 1'b1; gb = run_val_r;
          end else if (ended_r) begin
            fin = 1'b1;
            if (cnt_r != {8'd0, exp_len_r}) fin_st = rlecd_pkg::ST_LEN;
            else if ((crc_r ^ rlecd_pkg::CRC_INIT) != exp_crc_r) fin_st = rlecd_pkg::ST_CRC;
            else fin_st = rlecd_pkg::ST_FIN;
          end
        end
        default: ;
      endcase
    end
    if (give) begin
      crc_nxt = rlecd_pkg::crc_byte(crc_r, gb);
      cnt_nxt = cnt1[23:0];
      r.out_byte = gb; r.out_valid = 1'b1; r.status = rlecd_pkg::ST_OK;
    end
    if (fin) begin
      mode_nxt = rlecd_pkg::MD_DONE; verdict_nxt = fin_st;
      r.done_res = 1'b1; r.status = fin_st;
    end
    r.decoded_length = cnt_nxt[15:0];
  end

  // next read address for the pattern replay
  always_comb begin
    rd_idx = pidx_r;
    if (req_valid) rd_idx = pidx_nxt;
  end

  // pattern memory: one write, one registered read; a write to the address
  // being read is forwarded (one-byte pattern turns to replay right away)
  always_ff @(posedge clk) begin
    if (req_valid && wr_en) mem[wr_addr] <= req.in_byte;
    if (rd_idx >= 9'(PATTERN_DEPTH)) pat_q_r <= 8'd0;
    else if (req_valid && wr_en && wr_addr == rd_idx[AW-1:0]) pat_q_r <= req.in_byte;
    else pat_q_r <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rlecd_pkg::MD_IDLE; hidx_r <= 3'd0; verdict_r <= rlecd_pkg::ST_OK;
      exp_len_r <= 16'd0; exp_crc_r <= 32'd0; crc_r <= rlecd_pkg::CRC_INIT;
      cnt_r <= 24'd0; pend_r <= 8'd0; is_run_r <= 1'b0; run_val_r <= 8'd0;
      held_v_r <= 1'b0; period_r <= 8'd0; reps_r <= 16'd0; pidx_r <= 9'd0;
      ended_r <= 1'b0; res_valid <= 1'b0;
    end else begin
      res_valid <= req_valid;
      if (req_valid) begin
        mode_r <= mode_nxt; hidx_r <= hidx_nxt; verdict_r <= verdict_nxt;
        exp_len_r <= exp_len_nxt; exp_crc_r <= exp_crc_nxt; crc_r <= crc_nxt;
        cnt_r <= cnt_nxt; pend_r <= pend_nxt; is_run_r <= is_run_nxt;
        run_val_r <= run_val_nxt; held_v_r <= held_v_nxt;
        period_r <= period_nxt; reps_r <= reps_nxt; pidx_r <= pidx_nxt;
        ended_r <= ended_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      held_r <= held_nxt;
      res    <= r;
    end
  end

endmodule
